>>> rtl/core/wsd_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
// Parse phase codes, event kinds, frame opcodes and the event record.
// No dependencies.
package wsd_pkg;

   // Parse phases
   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_EXT16 = 3'd2;
   localparam logic [2:0] PH_EXT64 = 3'd3;
   localparam logic [2:0] PH_MASK  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;

   // Event kinds
   localparam logic [2:0] EV_TEXT       = 3'd0;
   localparam logic [2:0] EV_MSG_END    = 3'd1;
   localparam logic [2:0] EV_PING_BYTE  = 3'd2;
   localparam logic [2:0] EV_PING_EMPTY = 3'd3;
   localparam logic [2:0] EV_PONG       = 3'd4;
   localparam logic [2:0] EV_CLOSE      = 3'd5;
   localparam logic [2:0] EV_ABORT      = 3'd6;
   localparam logic [2:0] EV_OVERSIZE   = 3'd7;

   // Frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Short length codes that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam int unsigned MAX_LEN_W = 27;
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 27'd67108864;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] data;
      logic       last;
   } wsd_event_type;

endpackage

>>> rtl/core/wsd_parser.sv
// Frame parser state and per-byte step logic of the WebSocket frame deframer.
// Consumes one byte per step and produces at most one event combinationally.
// Depends on wsd_pkg.
module wsd_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [7:0]                          rx_byte,
   input  logic [wsd_pkg::MAX_LEN_W-1:0]       max_len,
   output wsd_pkg::wsd_event_type              evt
);
   import wsd_pkg::*;

   logic [2:0]  phase_ff,  phase_in;
   logic [2:0]  count_ff,  count_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff,    key_in;
   logic [1:0]  idx_ff,    idx_in;
   logic        final_ff,  final_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic        await_ff,  await_in;
   logic        text_ff,   text_in;
   logic        halted_ff, halted_in;

   logic        after_len;
   logic        hdr_end;
   logic        in_msg;
   logic        text_next;
   logic        pay_end;
   logic [7:0]  key_byte;
   logic [7:0]  plain;

   // Unmask the payload byte with the key byte in rotation
   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      plain   = rx_byte ^ key_byte;
      pay_end = (length_ff == 64'd1);
   end

   // Step the parser by one byte
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      final_in  = final_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      await_in  = await_ff;
      text_in   = text_ff;
      halted_in = halted_ff;
      evt       = '0;
      after_len = 1'b0;
      hdr_end   = 1'b0;
      in_msg    = 1'b0;
      text_next = text_ff;

      if (step && !halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
               // a new data frame drops an open fragmented message
               if ((rx_byte[3:0] == OP_TEXT || rx_byte[3:0] == OP_BINARY) && await_ff) begin
                  await_in = 1'b0;
                  text_in  = 1'b0;
                  evt      = '{valid: 1'b1, kind: EV_ABORT, data: 8'd0, last: 1'b0};
               end
            end
            PH_HDR1: begin
               masked_in = rx_byte[7];
               key_in    = '0;
               count_in  = '0;
               length_in = '0;
               if (rx_byte[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  length_in = {57'd0, rx_byte[6:0]};
                  after_len = 1'b1;
               end
            end
            PH_EXT16: begin
               length_in = {length_ff[55:0], rx_byte};
               if (count_ff >= 3'd1) begin
                  after_len = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_EXT64: begin
               length_in = {length_ff[55:0], rx_byte};
               if (count_ff >= 3'd7) begin
                  after_len = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               if (count_ff >= 3'd3) begin
                  hdr_end = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_DATA: begin
               if (length_ff == 64'd0) begin
                  phase_in = PH_HDR0;
               end else begin
                  idx_in    = idx_ff + 2'd1;
                  length_in = length_ff - 64'd1;
                  if (pay_end) begin
                     phase_in = PH_HDR0;
                  end
                  case (opcode_ff)
                     OP_CLOSE: begin
                        if (pay_end) begin
                           halted_in = 1'b1;
                           evt = '{valid: 1'b1, kind: EV_CLOSE, data: 8'd0, last: 1'b0};
                        end
                     end
                     OP_PING: begin
                        evt = '{valid: 1'b1, kind: EV_PING_BYTE, data: plain, last: pay_end};
                     end
                     OP_PONG: begin
                        if (pay_end) begin
                           evt = '{valid: 1'b1, kind: EV_PONG, data: 8'd0, last: 1'b0};
                        end
                     end
                     default: begin
                        if (opcode_ff <= OP_BINARY && text_ff) begin
                           if (pay_end && final_ff) begin
                              text_in = 1'b0;
                           end
                           evt = '{valid: 1'b1, kind: EV_TEXT, data: plain,
                                   last: pay_end && final_ff};
                        end
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // Length complete: fetch the mask key or close the header
         if (after_len) begin
            if (masked_in) begin
               phase_in = PH_MASK;
               count_in = '0;
            end else begin
               hdr_end = 1'b1;
            end
         end

         // Header complete: check size, track the message, report empty frames
         if (hdr_end) begin
            count_in = '0;
            idx_in   = '0;
            phase_in = PH_HDR0;
            if (length_in > {37'd0, max_len}) begin
               halted_in = 1'b1;
               evt = '{valid: 1'b1, kind: EV_OVERSIZE, data: 8'd0, last: 1'b0};
            end else begin
               in_msg = (opcode_ff == OP_TEXT) || (opcode_ff == OP_BINARY) ||
                        (opcode_ff == OP_CONT && await_ff);
               if (in_msg) begin
                  if (opcode_ff != OP_CONT) begin
                     text_next = (opcode_ff == OP_TEXT);
                  end
                  await_in = !final_ff;
                  text_in  = text_next;
               end
               if (length_in != 64'd0) begin
                  phase_in = PH_DATA;
               end else if (opcode_ff == OP_CLOSE) begin
                  halted_in = 1'b1;
                  evt = '{valid: 1'b1, kind: EV_CLOSE, data: 8'd0, last: 1'b0};
               end else if (opcode_ff == OP_PING) begin
                  evt = '{valid: 1'b1, kind: EV_PING_EMPTY, data: 8'd0, last: 1'b0};
               end else if (opcode_ff == OP_PONG) begin
                  evt = '{valid: 1'b1, kind: EV_PONG, data: 8'd0, last: 1'b0};
               end else if (in_msg && final_ff) begin
                  text_in = 1'b0;
                  if (text_next) begin
                     evt = '{valid: 1'b1, kind: EV_MSG_END, data: 8'd0, last: 1'b0};
                  end
               end
            end
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         count_ff  <= '0;
         length_ff <= '0;
         key_ff    <= '0;
         idx_ff    <= '0;
         final_ff  <= 1'b0;
         opcode_ff <= '0;
         masked_ff <= 1'b0;
         await_ff  <= 1'b0;
         text_ff   <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         final_ff  <= final_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         await_ff  <= await_in;
         text_ff   <= text_in;
         halted_ff <= halted_in;
      end
   end

endmodule

>>> rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer: one byte per cycle unless stalled, text/ping/control events out.
// A transferred byte enters the input register; the parser step then loads its event into
// the result register when that register can take it, and waits while rsp is stalled.
// Throughput: one byte per cycle while rsp is not stalled; the parser step is combinational.
// Reset (synchronous, active high) returns to header parsing, clears halt and loads
// max_payload_len with 64 MiB. Depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_event_kind,
   output logic [7:0]                      rsp_data_byte,
   output logic                            rsp_last_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wsd_pkg::MAX_LEN_W-1:0]   csr_max_payload_len
);
   import wsd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff,  in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   logic [2:0]           out_kind_ff, out_kind_in;
   logic [7:0]           out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;
   logic [MAX_LEN_W-1:0] max_len_ff, max_len_in;
   logic                 advance;
   logic                 req_take;
   wsd_event_type        evt;

   // Step the parser when the result register can take its output
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .evt     (evt)
   );

   // Input register, result register and configuration register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = evt.valid;
         out_kind_in  = evt.kind;
         out_data_in  = evt.data;
         out_last_in  = evt.last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      max_len_in = max_len_ff;
      if (csr_valid && csr_ready) begin
         max_len_in = csr_max_payload_len;
      end
   end

   // Hold control state; payload registers carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         max_len_ff   <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_last_byte  = out_last_ff;

   // Only byte-carrying events have data or a last mark
   a_ctrl_event_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !(out_kind_ff == EV_TEXT || out_kind_ff == EV_PING_BYTE)
      |-> out_data_ff == 8'd0 && !out_last_ff)
      else $error("control event carries data or last mark");

   // Oversize halts parsing: nothing follows its transfer
   a_halt_after_oversize: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_stall && out_kind_ff == EV_OVERSIZE |=> !out_valid_ff)
      else $error("event produced after oversize halt");

   // A held input byte stays put until the parser steps
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost or changed");

endmodule
